@@ hw/rtl/decimal_key_to_serial_lookup_defines.svh @@
// Assertion macros used by dksl_ctrl in the key lookup RTL.
// Expects the including module to have clk and arst_n in scope.
`ifndef DECIMAL_KEY_TO_SERIAL_LOOKUP_DEFINES_SVH
`define DECIMAL_KEY_TO_SERIAL_LOOKUP_DEFINES_SVH

// Same-cycle implication, off while reset is asserted
`define DKSL_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, off while reset is asserted
`define DKSL_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/dksl_pkg.sv @@
// Types and constants for the decimal key to serial lookup block.
// No dependencies; used by dksl_ctrl, dksl_dp and the top level.
`default_nettype none

package dksl_pkg;

	localparam int KEY_W        = 50;
	localparam int SERIAL_W     = 44;
	localparam int IDX_W        = 10;
	localparam int CNT_W        = 11;
	localparam int KEY_CHARS    = 15;
	localparam int KEY_CHARS_W  = 8 * KEY_CHARS;
	localparam int CONV_DIGITS  = 3;
	localparam int CONV_STEPS   = KEY_CHARS / CONV_DIGITS;
	localparam int SER_DIGITS   = 13;
	localparam int SER_HI_CHARS = 8;
	localparam int SER_LO_CHARS = SER_DIGITS - SER_HI_CHARS;
	localparam int BCD_DIGITS   = 14;
	localparam int BCD_W        = 4 * BCD_DIGITS;
	localparam int BCD_BITS     = 4;
	localparam int BCD_STEPS    = SERIAL_W / BCD_BITS;
	localparam int STEP_W       = 4;

	localparam logic [7:0] ASCII_ZERO = 8'h30;
	localparam logic [7:0] ASCII_NINE = 8'h39;

	localparam logic KIND_LOAD   = 1'b0;
	localparam logic KIND_LOOKUP = 1'b1;

	typedef struct packed {
		logic                 kind;
		logic [IDX_W-1:0]     entry_index;
		logic [KEY_W-1:0]     entry_key;
		logic [SERIAL_W-1:0]  entry_serial;
		logic [63:0]          key_chars_high;
		logic [55:0]          key_chars_low;
	} dksl_req_t;

	typedef struct packed {
		logic                 found;
		logic                 bad_char;
		logic [SERIAL_W-1:0]  serial_value;
		logic [63:0]          serial_chars_high;
		logic [39:0]          serial_chars_low;
	} dksl_rsp_t;

	typedef struct packed {
		logic write;
		logic capture;
		logic conv;
		logic read;
		logic probe;
		logic bcd;
		logic emit;
	} dksl_cmd_t;

	typedef struct packed {
		logic skip;
		logic eq;
		logic miss;
		logic serial_zero;
	} dksl_sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/dksl_ctrl.sv @@
// Sequencer for the lookup: conversion, search probes, BCD steps, result.
// Depends on dksl_pkg and decimal_key_to_serial_lookup_defines.svh.
`default_nettype none
`include "decimal_key_to_serial_lookup_defines.svh"

module dksl_ctrl import dksl_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	input  wire logic      kind,
	input  wire dksl_sts_t sts,
	output dksl_cmd_t      cmd,
	output logic           busy,
	output logic           done
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_READ,
		ST_CMP,
		ST_BCD,
		ST_FIN
	} state_t;

	state_t             state_q;
	logic [STEP_W-1:0]  step_q;
	logic               busy_q;
	logic               done_q;

	// Decode commands from the current state
	always_comb begin
		cmd         = '0;
		cmd.write   = (state_q == ST_IDLE) && start && (kind == KIND_LOAD);
		cmd.capture = (state_q == ST_IDLE) && start && (kind == KIND_LOOKUP);
		cmd.conv    = (state_q == ST_CONV);
		cmd.read    = (state_q == ST_READ);
		cmd.probe   = (state_q == ST_CMP);
		cmd.bcd     = (state_q == ST_BCD);
		cmd.emit    = (state_q == ST_FIN);
	end

	// Advance state, step counter and registered handshake outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					if (start && (kind == KIND_LOOKUP)) begin
						busy_q  <= 1'b1;
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					if (step_q == STEP_W'(CONV_STEPS - 1)) begin
						step_q  <= '0;
						state_q <= sts.skip ? ST_FIN : ST_READ;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_READ: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (sts.eq) begin
						state_q <= sts.serial_zero ? ST_FIN : ST_BCD;
					end else if (sts.miss) begin
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_READ;
					end
				end
				ST_BCD: begin
					if (step_q == STEP_W'(BCD_STEPS - 1)) begin
						step_q  <= '0;
						state_q <= ST_FIN;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_FIN: begin
					done_q  <= 1'b1;
					busy_q  <= 1'b0;
					state_q <= ST_IDLE;
				end
				default: begin
					busy_q  <= 1'b0;
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy = busy_q;
	assign done = done_q;

	`DKSL_ASSERT_IMP(a_done_not_busy, done_q, !busy_q, "result shown while still busy")
	`DKSL_ASSERT_NXT(a_done_single, done_q, !done_q, "result strobe longer than one cycle")
	`DKSL_ASSERT_NXT(a_lookup_busy, start && !busy_q && (kind == KIND_LOOKUP), busy_q,
		"accepted lookup did not raise busy")
	`DKSL_ASSERT_NXT(a_hit_exit, (state_q == ST_CMP) && sts.eq,
		(state_q == ST_BCD) || (state_q == ST_FIN), "hit did not end the search")

endmodule

`default_nettype wire

@@ hw/rtl/dksl_dp.sv @@
// Datapath: key/serial tables, digit conversion, search window, BCD unit.
// Depends on dksl_pkg; driven by commands from dksl_ctrl.
`default_nettype none

module dksl_dp import dksl_pkg::*; #(
	parameter int TABLE_DEPTH = 1024
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire dksl_req_t  req,
	input  wire logic       cfg_we,
	input  wire logic [CNT_W-1:0] cfg_wdata,
	input  wire dksl_cmd_t  cmd,
	output dksl_sts_t       sts,
	output dksl_rsp_t       rsp
);

	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int PW = ((IW > CNT_W) ? IW : CNT_W) + 1;

	logic [CNT_W-1:0]       count_q;
	logic [KEY_W-1:0]       key_mem [TABLE_DEPTH];
	logic [SERIAL_W-1:0]    ser_mem [TABLE_DEPTH];
	logic [KEY_W-1:0]       rd_key_q;
	logic [SERIAL_W-1:0]    rd_ser_q;
	logic [KEY_CHARS_W-1:0] chars_q;
	logic [KEY_W-1:0]       key_q;
	logic                   bad_q;
	logic                   empty_q;
	logic [PW-1:0]          lo_q;
	logic [PW-1:0]          hi_q;
	logic [PW-1:0]          pos_q;
	logic [SERIAL_W-1:0]    serial_q;
	logic [SERIAL_W-1:0]    bin_q;
	logic [BCD_W-1:0]       bcd_q;
	dksl_rsp_t              rsp_q;

	logic [KEY_CHARS_W-1:0] chars_in;
	logic [PW-1:0]          count_ext;
	logic [PW-1:0]          count_sat;
	logic [PW-1:0]          idx_ext;
	logic                   idx_ok;
	logic                   bad_in;
	logic [9:0]             grp;
	logic [KEY_W-1:0]       key_next;
	logic                   gt;
	logic                   eq;
	logic [PW-1:0]          lo_n;
	logic [PW-1:0]          hi_n;
	logic [PW-1:0]          pos_n;
	logic                   miss;
	logic [BCD_W-1:0]       bcd_n;
	logic [SERIAL_W-1:0]    bin_n;
	dksl_rsp_t              rsp_n;

	assign chars_in  = {req.key_chars_high, req.key_chars_low};
	assign count_ext = PW'(count_q);
	assign count_sat = (count_ext > PW'(TABLE_DEPTH)) ? PW'(TABLE_DEPTH) : count_ext;
	assign idx_ext   = PW'(req.entry_index);
	assign idx_ok    = idx_ext < PW'(TABLE_DEPTH);

	// Hold the entry count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CNT_W'(1);
		end else if (cfg_we) begin
			count_q <= cfg_wdata;
		end
	end

	// Flag any key character outside '0'..'9'
	always_comb begin
		bad_in = 1'b0;
		for (int i = 0; i < KEY_CHARS; i++) begin
			if (chars_in[8*i +: 8] < ASCII_ZERO || chars_in[8*i +: 8] > ASCII_NINE) begin
				bad_in = 1'b1;
			end
		end
	end

	// Fold three digits per step into the key: key * 1000 + group
	assign grp = (10'(chars_q[KEY_CHARS_W-5 -: 4]) * 10'd100)
		+ (10'(chars_q[KEY_CHARS_W-13 -: 4]) * 10'd10)
		+ 10'(chars_q[KEY_CHARS_W-21 -: 4]);
	assign key_next = (key_q << 10) - (key_q << 4) - (key_q << 3) + KEY_W'(grp);

	// Narrow the search window around the probe
	assign gt    = key_q > rd_key_q;
	assign eq    = key_q == rd_key_q;
	assign lo_n  = gt ? (pos_q + 1'b1) : lo_q;
	assign hi_n  = gt ? hi_q : pos_q;
	assign miss  = lo_n >= hi_n;
	assign pos_n = lo_n + ((hi_n - lo_n - 1'b1) >> 1);

	// Run four double-dabble bit steps
	always_comb begin
		logic [BCD_W-1:0]    b;
		logic [SERIAL_W-1:0] s;
		b = bcd_q;
		s = bin_q;
		for (int k = 0; k < BCD_BITS; k++) begin
			for (int j = 0; j < BCD_DIGITS; j++) begin
				if (b[4*j +: 4] >= 4'd5) begin
					b[4*j +: 4] = b[4*j +: 4] + 4'd3;
				end
			end
			{b, s} = {b, s} << 1;
		end
		bcd_n = b;
		bin_n = s;
	end

	// Build the result, ASCII digits most significant first
	always_comb begin
		rsp_n              = '0;
		rsp_n.found        = serial_q != '0;
		rsp_n.bad_char     = bad_q;
		rsp_n.serial_value = serial_q;
		if (serial_q != '0) begin
			for (int i = 0; i < SER_HI_CHARS; i++) begin
				rsp_n.serial_chars_high[63-8*i -: 8] =
					ASCII_ZERO + 8'(bcd_q[4*(SER_DIGITS-1-i) +: 4]);
			end
			for (int i = 0; i < SER_LO_CHARS; i++) begin
				rsp_n.serial_chars_low[39-8*i -: 8] =
					ASCII_ZERO + 8'(bcd_q[4*(SER_LO_CHARS-1-i) +: 4]);
			end
		end
	end

	// Write on load, read at the probe position
	always_ff @(posedge clk) begin
		if (cmd.write && idx_ok) begin
			key_mem[idx_ext[IW-1:0]] <= req.entry_key;
			ser_mem[idx_ext[IW-1:0]] <= req.entry_serial;
		end
		if (cmd.read) begin
			rd_key_q <= key_mem[pos_q[IW-1:0]];
			rd_ser_q <= ser_mem[pos_q[IW-1:0]];
		end
	end

	// Advance the lookup working registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			chars_q  <= chars_in;
			bad_q    <= bad_in;
			empty_q  <= count_sat == '0;
			key_q    <= '0;
			lo_q     <= '0;
			hi_q     <= count_sat;
			pos_q    <= count_sat >> 1;
			serial_q <= '0;
		end
		if (cmd.conv) begin
			key_q   <= key_next;
			chars_q <= chars_q << (8 * CONV_DIGITS);
		end
		if (cmd.probe) begin
			if (eq) begin
				serial_q <= rd_ser_q;
				bin_q    <= rd_ser_q;
				bcd_q    <= '0;
			end else begin
				lo_q  <= lo_n;
				hi_q  <= hi_n;
				pos_q <= pos_n;
			end
		end
		if (cmd.bcd) begin
			bcd_q <= bcd_n;
			bin_q <= bin_n;
		end
		if (cmd.emit) begin
			rsp_q <= rsp_n;
		end
	end

	assign sts.skip        = bad_q | empty_q;
	assign sts.eq          = eq;
	assign sts.miss        = miss;
	assign sts.serial_zero = rd_ser_q == '0;
	assign rsp             = rsp_q;

endmodule

`default_nettype wire

@@ hw/rtl/decimal_key_to_serial_lookup.sv @@
// Load: busy stays low, a load may follow every cycle; no result.
// Lookup: conversion, P probes (at most floor(log2(count)) + 1, each a table
// read then a compare), BCD steps on a nonzero hit; bad chars or an empty
// window skip the probes. busy is high until the result cycle.
// Reset clears control and sets entry_count to 1; table contents stay as is.
// Results are flagged by a one-cycle done strobe; the receiver cannot stall them.
`default_nettype none

module decimal_key_to_serial_lookup import dksl_pkg::*; #(
	parameter int TABLE_DEPTH = 1024
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire dksl_req_t        req,
	input  wire logic             cfg_we,
	input  wire logic [CNT_W-1:0] cfg_wdata,
	output logic                  done,
	output dksl_rsp_t             rsp
);

	dksl_cmd_t cmd;
	dksl_sts_t sts;

	// Sequence each request
	dksl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.kind   (req.kind),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// Tables, conversion and search
	dksl_dp #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.sts       (sts),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire

@@ verif/decimal_key_to_serial_lookup_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for decimal_key_to_serial_lookup: table loads and ASCII key lookups.
// Depends on dksl_pkg and the block's RTL; keeps its own copy of the table to predict results.

module decimal_key_to_serial_lookup_tb;
	import dksl_pkg::*;

	localparam int TABLE_DEPTH = 1024;
	localparam logic [63:0] MAX_KEY = 64'd999999999999999;
	localparam logic [63:0] KEY_SPAN = 64'd1000000000000000;
	localparam logic [63:0] SERIAL_SPAN = 64'd10000000000000;
	localparam logic [63:0] SERIAL_TOP = 64'd17592186044416;
	localparam logic [63:0] BUCKET = 64'd976562500000;
	localparam int SETTLE = 48;
	localparam int CYCLE_LIMIT = 600000;

	// Track table contents and the search window; hold expected lookup answers in order
	class lookup_scoreboard;
		logic [KEY_W-1:0] key_mem [TABLE_DEPTH];
		logic [SERIAL_W-1:0] serial_mem [TABLE_DEPTH];
		logic [CNT_W-1:0] entry_count = 1;
		dksl_rsp_t expected_rsp [$];
		int errors = 0;
		int checked = 0;
		int loads = 0;
		int lookups = 0;
		int hits = 0;
		int bad_keys = 0;

		// Binary search over the first entry_count entries, first probe at count/2
		function logic [SERIAL_W-1:0] search_serial(logic [KEY_W-1:0] key);
			int cnt, lo_pos, hi_pos, pos;
			cnt = int'(entry_count);
			if (cnt > TABLE_DEPTH)
				cnt = TABLE_DEPTH;
			if (cnt == 0)
				return '0;
			lo_pos = 0;
			hi_pos = cnt - 1;
			pos = cnt / 2;
			while (1) begin
				if (key == key_mem[pos])
					return serial_mem[pos];
				if (key > key_mem[pos]) begin
					lo_pos = pos + 1;
					if (lo_pos > hi_pos)
						return '0;
				end else begin
					hi_pos = pos - 1;
					if (hi_pos < lo_pos)
						return '0;
				end
				pos = (hi_pos - lo_pos) / 2 + lo_pos;
			end
		endfunction

		// Convert the ASCII key, search, and format the serial as 13 digits
		function dksl_rsp_t predict_lookup(dksl_req_t r);
			dksl_rsp_t res;
			logic [119:0] chars;
			logic [103:0] digs;
			logic [7:0] ch;
			logic [63:0] key, rest;
			logic [SERIAL_W-1:0] ser;
			bit bad;
			chars = {r.key_chars_high, r.key_chars_low};
			key = '0;
			bad = 0;
			for (int i = 0; i < KEY_CHARS; i++) begin
				ch = chars[119 - 8 * i -: 8];
				if (ch < ASCII_ZERO || ch > ASCII_NINE)
					bad = 1;
				else
					key = key * 10 + 64'(ch - ASCII_ZERO);
			end
			ser = bad ? '0 : search_serial(key[KEY_W-1:0]);
			res = '0;
			res.bad_char = bad;
			res.found = (ser != 0);
			res.serial_value = ser;
			if (ser != 0) begin
				rest = 64'(ser);
				for (int i = SER_DIGITS - 1; i >= 0; i--) begin
					digs[103 - 8 * i -: 8] = ASCII_ZERO + 8'(rest % 10);
					rest = rest / 10;
				end
				res.serial_chars_high = digs[103:40];
				res.serial_chars_low = digs[39:0];
			end
			return res;
		endfunction

		// Apply a load to the table copy, or queue the answer of a lookup
		function void note_request(dksl_req_t r);
			dksl_rsp_t res;
			if (r.kind == KIND_LOAD) begin
				key_mem[r.entry_index] = r.entry_key;
				serial_mem[r.entry_index] = r.entry_serial;
				loads++;
			end else begin
				res = predict_lookup(r);
				lookups++;
				if (res.found)
					hits++;
				if (res.bad_char)
					bad_keys++;
				expected_rsp.push_back(res);
			end
		endfunction

		task report_mismatch(string what);
			errors++;
			if (errors <= 40)
				$display("%0t mismatch: %s", $realtime, what);
		endtask

		// Compare one strobed result against the oldest expected answer
		task check_result(dksl_rsp_t got);
			dksl_rsp_t exp;
			if (expected_rsp.size() == 0) begin
				report_mismatch($sformatf("result with no pending lookup: %h", got));
				return;
			end
			exp = expected_rsp.pop_front();
			checked++;
			if (got.found !== exp.found)
				report_mismatch($sformatf("found %b, want %b", got.found, exp.found));
			if (got.bad_char !== exp.bad_char)
				report_mismatch($sformatf("bad_char %b, want %b", got.bad_char, exp.bad_char));
			if (got.serial_value !== exp.serial_value)
				report_mismatch($sformatf("serial_value %0d, want %0d",
					got.serial_value, exp.serial_value));
			if (got.serial_chars_high !== exp.serial_chars_high)
				report_mismatch($sformatf("serial_chars_high %h, want %h",
					got.serial_chars_high, exp.serial_chars_high));
			if (got.serial_chars_low !== exp.serial_chars_low)
				report_mismatch($sformatf("serial_chars_low %h, want %h",
					got.serial_chars_low, exp.serial_chars_low));
		endtask
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	dksl_req_t req = '0;
	logic cfg_we = 1'b0;
	logic [CNT_W-1:0] cfg_wdata = '0;
	logic done;
	dksl_rsp_t rsp;

	lookup_scoreboard sb = new();
	int sender_idle_pct = 13;
	int count_writes = 0;
	int cycle_count = 0;

	decimal_key_to_serial_lookup #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.done(done),
		.rsp(rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Check every strobed result
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(rsp);
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d lookups pending", cycle_count,
				sb.expected_rsp.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic logic [63:0] random_key();
		return {$urandom, $urandom} % KEY_SPAN;
	endfunction

	// Mostly 13-digit serials, with some zeros and some above 13 digits
	function automatic logic [SERIAL_W-1:0] random_serial();
		int pick;
		pick = $urandom_range(99);
		if (pick < 6)
			return '0;
		if (pick < 12)
			return SERIAL_W'(SERIAL_SPAN + {$urandom, $urandom} % (SERIAL_TOP - SERIAL_SPAN));
		return SERIAL_W'({$urandom, $urandom} % SERIAL_SPAN);
	endfunction

	function automatic dksl_req_t random_req();
		dksl_req_t r;
		r.kind = 1'($urandom_range(1));
		r.entry_index = IDX_W'($urandom);
		r.entry_key = KEY_W'({$urandom, $urandom});
		r.entry_serial = SERIAL_W'({$urandom, $urandom});
		r.key_chars_high = {$urandom, $urandom};
		r.key_chars_low = 56'({$urandom, $urandom});
		return r;
	endfunction

	// Render a number as 15 ASCII digits, most significant first
	function automatic logic [119:0] key_to_chars(logic [63:0] v);
		logic [119:0] c;
		for (int i = 0; i < KEY_CHARS; i++) begin
			c[8 * i +: 8] = ASCII_ZERO + 8'(v % 10);
			v = v / 10;
		end
		return c;
	endfunction

	// Hold the request until accepted, after an optional random gap
	task automatic send_request(input dksl_req_t r);
		if ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			if ($urandom_range(3) == 0)
				repeat ($urandom_range(1, 45)) @(posedge clk);
			else
				repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		start <= 1'b1;
		req <= r;
		do
			@(posedge clk);
		while (busy);
		sb.note_request(r);
	endtask

	task automatic load_entry(input int idx, input logic [KEY_W-1:0] key,
		input logic [SERIAL_W-1:0] serial);
		dksl_req_t r;
		r = random_req();
		r.kind = KIND_LOAD;
		r.entry_index = IDX_W'(idx);
		r.entry_key = key;
		r.entry_serial = serial;
		send_request(r);
	endtask

	task automatic lookup_chars(input logic [119:0] c);
		dksl_req_t r;
		r = random_req();
		r.kind = KIND_LOOKUP;
		{r.key_chars_high, r.key_chars_low} = c;
		send_request(r);
	endtask

	task automatic lookup_key(input logic [63:0] v);
		lookup_chars(key_to_chars(v));
	endtask

	// Corrupt one to three characters with non-digit bytes
	task automatic lookup_bad(input logic [63:0] v);
		logic [119:0] c;
		logic [7:0] b;
		int pos;
		c = key_to_chars(v);
		repeat ($urandom_range(1, 3)) begin
			pos = $urandom_range(KEY_CHARS - 1);
			do
				b = 8'($urandom_range(255));
			while (b >= ASCII_ZERO && b <= ASCII_NINE);
			c[119 - 8 * pos -: 8] = b;
		end
		lookup_chars(c);
	endtask

	// Stop sending until every pending lookup has answered, then let the block settle
	task automatic drain();
		start <= 1'b0;
		while (sb.expected_rsp.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_entry_count(input logic [CNT_W-1:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.entry_count = v;
		count_writes++;
	endtask

	// Random mix of hits, near misses, random keys, bad characters and table updates
	task automatic run_phase(input int unsigned count, input int items);
		int eff, idx, pick;
		logic [63:0] key;
		set_entry_count(CNT_W'(count));
		eff = (count > TABLE_DEPTH) ? TABLE_DEPTH : int'(count);
		for (int n = 0; n < items; n++) begin
			pick = $urandom_range(99);
			if (eff > 0 && $urandom_range(99) < 85)
				idx = $urandom_range(eff - 1);
			else
				idx = $urandom_range(TABLE_DEPTH - 1);
			key = 64'(sb.key_mem[idx]);
			if (key > MAX_KEY)
				key = random_key();
			if (pick < 12) begin
				if ($urandom_range(3) != 0)
					load_entry(idx, sb.key_mem[idx], random_serial());
				else
					load_entry(idx, KEY_W'({$urandom, $urandom}), random_serial());
			end else if (pick < 62) begin
				lookup_key(key);
			end else if (pick < 72) begin
				if ($urandom_range(1) == 0)
					lookup_key((key == MAX_KEY) ? key - 1 : key + 1);
				else
					lookup_key((key == 0) ? key + 1 : key - 1);
			end else if (pick < 84) begin
				lookup_key(random_key());
			end else if (pick < 92) begin
				lookup_bad(key);
			end else begin
				lookup_key(($urandom_range(1) == 0) ? 64'd0 : MAX_KEY);
			end
			if ($urandom_range(99) < 2)
				drain();
		end
	endtask

	initial begin
		logic [119:0] c;
		int unsigned phase_counts [10];

		phase_counts = '{1024, 2047, 1, 2, 3, 0, 1025, 5, 1024, 6};
		phase_counts[7] = $urandom_range(4, TABLE_DEPTH - 1);
		phase_counts[9] = $urandom_range(4, TABLE_DEPTH - 1);

		// Hold reset at start, then release it
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: single entry searched with the reset count of one
		load_entry(0, 50'd123456789012345, 44'd9876543210123);
		lookup_key(64'd123456789012345);
		lookup_key(64'd123456789012346);
		lookup_key(64'd123456789012344);
		lookup_key(64'd0);
		lookup_key(MAX_KEY);
		c = key_to_chars(64'd123456789012345);
		c[119 -: 8] = 8'h2F;
		lookup_chars(c);
		c = key_to_chars(64'd123456789012345);
		c[7:0] = 8'h3A;
		lookup_chars(c);
		c = key_to_chars(64'd123456789012345);
		c[63:56] = 8'hFF;
		c[71:64] = 8'h00;
		lookup_chars(c);
		// Zero serial reads as not found
		load_entry(0, 50'd0, 44'd0);
		lookup_key(64'd0);
		// Largest key and serial
		load_entry(0, KEY_W'(MAX_KEY), 44'd9999999999999);
		lookup_key(MAX_KEY);
		// Leading zeros in both key and serial
		load_entry(0, 50'd5, 44'd1);
		lookup_key(64'd5);
		// Serial wider than 13 digits
		load_entry(0, 50'd7, {SERIAL_W{1'b1}});
		lookup_key(64'd7);
		load_entry(TABLE_DEPTH - 1, {KEY_W{1'b1}}, {SERIAL_W{1'b1}});
		// Empty search window
		set_entry_count('0);
		lookup_key(64'd7);
		lookup_key(64'd5);

		// Fill the whole table with ascending keys, one per bucket
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (i == 0)
				load_entry(i, '0, random_serial());
			else if (i == TABLE_DEPTH - 1)
				load_entry(i, KEY_W'(MAX_KEY), random_serial());
			else
				load_entry(i, KEY_W'(i * BUCKET + {$urandom, $urandom} % BUCKET),
					random_serial());
		end

		// Random phases across window sizes; sender idling changes along the way
		for (int p = 0; p < 10; p++) begin
			if (p < 2)
				sender_idle_pct = 13;
			else if (p < 6)
				sender_idle_pct = 66;
			else
				sender_idle_pct = 0;
			run_phase(phase_counts[p], 88);
		end

		drain();
		$display("Sent %0d table loads and %0d lookups (%0d expected hits, %0d with bad key",
			sb.loads, sb.lookups, sb.hits, sb.bad_keys);
		$display("characters) over %0d entry_count settings; %0d results checked, %0d mismatches.",
			count_writes, sb.checked, sb.errors);
		if (sb.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
